FILE: rtl/trfp_pkg.sv
`timescale 1ns / 1ps

package trfp_pkg;

  // Frame layout.
  localparam int PAYLOAD_LEN = 20;
  localparam int END_POS     = 21;
  localparam int NUM_TARGETS = 4;
  localparam int TARGET_LEN  = 5;

  localparam int POS_W = 5;
  localparam int IDX_W = 5;

  // Configuration register indexes and reset values.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_END_MARKER   = 2'd1;
  localparam logic [7:0] START_MARKER_RESET = 8'hFF;
  localparam logic [7:0] END_MARKER_RESET   = 8'hFE;

  // Operation that the front end hands to the back end.
  typedef enum logic {
    OP_STORE = 1'b0,
    OP_EMIT  = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } op_t;

  // Status of the front end, watched by the top level.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             push;
  } front_stat_t;

  typedef struct packed {
    logic [7:0]  visible;
    logic [15:0] heading;
    logic [15:0] range;
  } target_t;

  typedef target_t [NUM_TARGETS-1:0] result_t;

endpackage

FILE: rtl/target_report_frame_parser.sv
`timescale 1ns / 1ps

// Target report frame parser.
// The input channel (in_valid, in_ready, rx_byte) takes one received byte per
// transfer. A start marker opens a 22-byte frame: 20 payload bytes for four
// targets, then an end byte. A frame whose end byte equals the end marker
// yields one transfer on the output channel (out_valid, out_ready) carrying
// visibility, heading and range for all four targets; any other frame yields
// nothing. The configuration channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data) writes the start marker (index 0) and end marker (index 1); it is
// always ready. The user must write it only while the parser is idle; the
// block itself does not enforce this. Throughput is one byte per cycle while
// in_ready is high, set by the byte position counter in the front end. The
// end operation enters the queue at the end byte transfer and moves into the
// output register once that register is free, behind any queued stores.
// Reset clears the position to hunting, restores the markers to 0xFF and
// 0xFE, empties the queue and drops the output valid flag. When the receiver
// stalls, payload stores keep draining; a pending result holds the end
// operation in the queue, and in_ready drops once the queue is full.
module target_report_frame_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  obj0_visible,
  output logic [15:0] obj0_heading,
  output logic [15:0] obj0_range,
  output logic [7:0]  obj1_visible,
  output logic [15:0] obj1_heading,
  output logic [15:0] obj1_range,
  output logic [7:0]  obj2_visible,
  output logic [15:0] obj2_heading,
  output logic [15:0] obj2_range,
  output logic [7:0]  obj3_visible,
  output logic [15:0] obj3_heading,
  output logic [15:0] obj3_range,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [trfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]  cfg_data
);

  logic                  start_marker;
  logic [7:0]            start_reg;
  logic [7:0]            end_reg;
  logic                  q_ready;
  logic                  q_valid;
  logic                  q_pop;
  trfp_pkg::op_t         push_op;
  trfp_pkg::op_t         head_op;
  trfp_pkg::front_stat_t fstat;
  trfp_pkg::result_t     result;

  assign cfg_ready    = 1'b1;
  assign start_marker = cfg_valid && (cfg_index == trfp_pkg::REG_START_MARKER);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_reg <= trfp_pkg::START_MARKER_RESET;
      end_reg   <= trfp_pkg::END_MARKER_RESET;
    end else if (cfg_valid) begin
      if (start_marker) begin
        start_reg <= cfg_data;
      end
      if (cfg_index == trfp_pkg::REG_END_MARKER) begin
        end_reg <= cfg_data;
      end
    end
  end

  trfp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .start_marker (start_reg),
    .end_marker   (end_reg),
    .queue_ready  (q_ready),
    .op           (push_op),
    .stat         (fstat)
  );

  trfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (fstat.push),
    .push_op (push_op),
    .ready   (q_ready),
    .pop     (q_pop),
    .valid   (q_valid),
    .pop_op  (head_op)
  );

  trfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (q_valid),
    .op        (head_op),
    .op_pop    (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  // Result fields to ports.
  assign obj0_visible = result[0].visible;
  assign obj0_heading = result[0].heading;
  assign obj0_range   = result[0].range;
  assign obj1_visible = result[1].visible;
  assign obj1_heading = result[1].heading;
  assign obj1_range   = result[1].range;
  assign obj2_visible = result[2].visible;
  assign obj2_heading = result[2].heading;
  assign obj2_range   = result[2].range;
  assign obj3_visible = result[3].visible;
  assign obj3_heading = result[3].heading;
  assign obj3_range   = result[3].range;

  // The byte position never leaves the frame range.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    fstat.pos <= trfp_pkg::POS_W'(trfp_pkg::END_POS))
    else $error("byte position out of range");

  // An end operation taken from the queue always produces a valid result.
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop && (head_op.kind == trfp_pkg::OP_EMIT) |=> out_valid)
    else $error("emit did not raise out_valid");

  // The back end only takes operations that are present.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // A pending result is not overwritten by a new frame.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(q_pop && (head_op.kind == trfp_pkg::OP_EMIT)))
    else $error("result overwritten while stalled");

endmodule

FILE: rtl/trfp_front.sv
`timescale 1ns / 1ps

module trfp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          start_marker,
  input  logic [7:0]          end_marker,
  input  logic                queue_ready,
  output trfp_pkg::op_t       op,
  output trfp_pkg::front_stat_t stat
);

  logic [trfp_pkg::POS_W-1:0] pos;
  logic [trfp_pkg::POS_W-1:0] pos_next;
  logic                       take;
  logic                       push;

  assign in_ready = queue_ready;
  assign take     = in_valid && queue_ready;

  // Classify the byte by its place in the frame.
  always_comb begin
    pos_next = pos;
    push     = 1'b0;
    op.kind  = trfp_pkg::OP_STORE;
    op.idx   = pos - trfp_pkg::POS_W'(1);
    op.data  = rx_byte;
    if (pos >= trfp_pkg::POS_W'(1) && pos <= trfp_pkg::POS_W'(trfp_pkg::PAYLOAD_LEN)) begin
      push     = take;
      pos_next = pos + trfp_pkg::POS_W'(1);
    end else if (pos == trfp_pkg::POS_W'(trfp_pkg::END_POS)) begin
      op.kind  = trfp_pkg::OP_EMIT;
      push     = take && (rx_byte == end_marker);
      pos_next = '0;
    end else begin
      // Hunting; stray positions are treated the same way.
      pos_next = (rx_byte == start_marker) ? trfp_pkg::POS_W'(1) : '0;
    end
  end

  // Byte position counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (take) begin
      pos <= pos_next;
    end
  end

  assign stat.pos  = pos;
  assign stat.push = push;

endmodule

FILE: rtl/trfp_queue.sv
`timescale 1ns / 1ps

module trfp_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  trfp_pkg::op_t push_op,
  output logic          ready,
  input  logic          pop,
  output logic          valid,
  output trfp_pkg::op_t pop_op
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  trfp_pkg::op_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign ready  = (count != CNT_W'(DEPTH));
  assign valid  = (count != '0);
  assign pop_op = slots[rd_ptr];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/trfp_back.sv
`timescale 1ns / 1ps

module trfp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  input  trfp_pkg::op_t     op,
  output logic              op_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output trfp_pkg::result_t result
);

  logic [7:0] staging [trfp_pkg::PAYLOAD_LEN];
  logic       emit;
  logic       store;

  // Stores never wait; an emit waits for a free output register.
  assign op_pop = op_valid &&
                  ((op.kind == trfp_pkg::OP_STORE) || !out_valid || out_ready);
  assign emit   = op_pop && (op.kind == trfp_pkg::OP_EMIT);
  assign store  = op_pop && (op.kind == trfp_pkg::OP_STORE);

  // Payload staging, one entry per payload byte.
  always_ff @(posedge clk) begin
    if (store) begin
      staging[op.idx] <= op.data;
    end
  end

  // Result register: gather the four targets at the end byte.
  always_ff @(posedge clk) begin
    if (emit) begin
      for (int t = 0; t < trfp_pkg::NUM_TARGETS; t++) begin
        result[t].visible <= staging[t * trfp_pkg::TARGET_LEN];
        result[t].heading <= {staging[t * trfp_pkg::TARGET_LEN + 2],
                              staging[t * trfp_pkg::TARGET_LEN + 1]};
        result[t].range   <= {staging[t * trfp_pkg::TARGET_LEN + 4],
                              staging[t * trfp_pkg::TARGET_LEN + 3]};
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BYTES   = 130;
  localparam int IDLE_PCT      = 36;

  // Register indexes past the two markers; writes to them must be dropped.
  localparam logic [trfp_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [trfp_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  // How a directed frame is checked.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_FILL
  } row_check_t;

  typedef struct {
    logic [7:0] lead;
    logic [7:0] fill;
    bit         ramp;
    logic [7:0] tail;
    row_check_t check;
  } frame_row_t;

  // Directed frames, sent with the reset markers in place.
  frame_row_t directed_rows [4] = '{
    '{8'h00, 8'h00, 1'b0, 8'hFE, CHK_FILL},
    '{8'hFE, 8'hFF, 1'b0, 8'hFE, CHK_FILL},
    '{8'h7F, 8'h10, 1'b1, 8'hFF, CHK_NONE},
    '{8'h80, 8'h5A, 1'b1, 8'hFE, CHK_MODEL}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [trfp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = 8'h00;

  logic in_ready, out_valid, cfg_ready;
  logic [7:0]  obj0_visible, obj1_visible, obj2_visible, obj3_visible;
  logic [15:0] obj0_heading, obj1_heading, obj2_heading, obj3_heading;
  logic [15:0] obj0_range, obj1_range, obj2_range, obj3_range;

  // Shadow of the parser: markers, frame position and staged payload.
  logic [7:0] start_mark = trfp_pkg::START_MARKER_RESET;
  logic [7:0] end_mark   = trfp_pkg::END_MARKER_RESET;
  logic [4:0] frame_pos  = '0;
  logic [7:0] staged [trfp_pkg::PAYLOAD_LEN];

  trfp_pkg::result_t frames_due [$];
  int mismatches = 0;
  int results_seen = 0;
  int frame_bytes = 0;
  bit no_gaps = 1'b0;

  target_report_frame_parser dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .obj0_visible (obj0_visible),
    .obj0_heading (obj0_heading),
    .obj0_range   (obj0_range),
    .obj1_visible (obj1_visible),
    .obj1_heading (obj1_heading),
    .obj1_range   (obj1_range),
    .obj2_visible (obj2_visible),
    .obj2_heading (obj2_heading),
    .obj2_range   (obj2_range),
    .obj3_visible (obj3_visible),
    .obj3_heading (obj3_heading),
    .obj3_range   (obj3_range),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // Hard stop in case the parser hangs.
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Advance the shadow parser by one byte; returns 1 when a frame completes with the end marker.
  function automatic bit parse_byte(input logic [7:0] b, output trfp_pkg::result_t frame);
    int base;
    frame = '0;
    if (frame_pos >= 1 && frame_pos <= trfp_pkg::PAYLOAD_LEN) begin
      staged[frame_pos - 5'd1] = b;
      frame_pos = frame_pos + 5'd1;
      return 1'b0;
    end
    if (frame_pos == trfp_pkg::END_POS) begin
      frame_pos = '0;
      if (b != end_mark) return 1'b0;
      for (int t = 0; t < trfp_pkg::NUM_TARGETS; t++) begin
        base = t * trfp_pkg::TARGET_LEN;
        frame[t].visible = staged[base];
        frame[t].heading = {staged[base + 2], staged[base + 1]};
        frame[t].range   = {staged[base + 4], staged[base + 3]};
      end
      return 1'b1;
    end
    // Hunting, and any position past the end byte.
    frame_pos = (b == start_mark) ? 5'd1 : 5'd0;
    return 1'b0;
  endfunction

  // Send one byte with an optional random gap, then update the shadow.
  task automatic send_byte(input logic [7:0] b, input bit push_model);
    bit done;
    trfp_pkg::result_t frame;
    if (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < IDLE_PCT) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    done = parse_byte(b, frame);
    if (done && push_model) frames_due.push_back(frame);
  endtask

  // Leaves cfg_valid high; the caller lowers it after its last write.
  task automatic write_reg(input logic [trfp_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == trfp_pkg::REG_START_MARKER) start_mark = val;
    else if (idx == trfp_pkg::REG_END_MARKER) end_mark = val;
  endtask

  // Stop feeding bytes and wait until every expected frame has come out.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pick a payload byte, biased toward the markers and the extremes.
  function automatic logic [7:0] pick_payload();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return start_mark;
    if (roll < 25) return end_mark;
    if (roll < 30) return 8'h00;
    if (roll < 35) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // One frame with random content, sometimes preceded by line noise.
  task automatic random_frame();
    logic [7:0] tail;
    int n;
    if ($urandom_range(0, 99) < 30) begin
      n = $urandom_range(1, 3);
      repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
    tail = ($urandom_range(0, 99) < 85) ? end_mark : 8'($urandom_range(0, 255));
    send_byte(start_mark, 1'b1);
    repeat (trfp_pkg::PAYLOAD_LEN) send_byte(pick_payload(), 1'b1);
    send_byte(tail, 1'b1);
    frame_bytes += trfp_pkg::END_POS + 1;
  endtask

  task automatic flag_mismatch(input string what, input int tgt,
                               input logic [15:0] want_v, input logic [15:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("result %0d target %0d %s: expected %h, got %h",
               results_seen, tgt, what, want_v, got_v);
  endtask

  // Receiver: random back-pressure, and each result transfer checked in order.
  always @(posedge clk) begin
    trfp_pkg::result_t seen, want;
    if (!rst && out_valid && out_ready) begin
      seen[0] = '{obj0_visible, obj0_heading, obj0_range};
      seen[1] = '{obj1_visible, obj1_heading, obj1_range};
      seen[2] = '{obj2_visible, obj2_heading, obj2_range};
      seen[3] = '{obj3_visible, obj3_heading, obj3_range};
      if (frames_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: transfer with no frame outstanding", results_seen);
      end else begin
        want = frames_due.pop_front();
        for (int t = 0; t < trfp_pkg::NUM_TARGETS; t++) begin
          if (seen[t].visible !== want[t].visible)
            flag_mismatch("visible", t, 16'(want[t].visible), 16'(seen[t].visible));
          if (seen[t].heading !== want[t].heading)
            flag_mismatch("heading", t, want[t].heading, seen[t].heading);
          if (seen[t].range !== want[t].range)
            flag_mismatch("range", t, want[t].range, seen[t].range);
        end
      end
      results_seen++;
    end
    out_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Main sequence.
  initial begin
    trfp_pkg::result_t filled;
    logic [7:0] b;
    logic [7:0] phase_start [6];
    logic [7:0] phase_end [6];

    foreach (staged[i]) staged[i] = 8'h00;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames with the reset markers.
    foreach (directed_rows[r]) begin
      send_byte(directed_rows[r].lead, 1'b1);
      send_byte(start_mark, 1'b1);
      for (int k = 0; k < trfp_pkg::PAYLOAD_LEN; k++) begin
        b = directed_rows[r].ramp ? 8'(directed_rows[r].fill + k) : directed_rows[r].fill;
        send_byte(b, 1'b1);
      end
      case (directed_rows[r].check)
        CHK_FILL: begin
          send_byte(directed_rows[r].tail, 1'b0);
          for (int t = 0; t < trfp_pkg::NUM_TARGETS; t++)
            filled[t] = '{directed_rows[r].fill,
                          {2{directed_rows[r].fill}}, {2{directed_rows[r].fill}}};
          frames_due.push_back(filled);
        end
        CHK_NONE: begin
          send_byte(directed_rows[r].tail, 1'b0);
        end
        default: begin
          send_byte(directed_rows[r].tail, 1'b1);
        end
      endcase
    end

    // Random phases, each with its own marker pair.
    phase_start = '{8'h00, 8'hFF, 8'hA5, 8'h00, 8'($urandom_range(0, 255)), 8'hFF};
    phase_end   = '{8'hFF, 8'h00, 8'hA5, 8'h00, 8'($urandom_range(0, 255)), 8'hFE};
    for (int p = 0; p < 6; p++) begin
      settle();
      if (p == 0) begin
        // Spare indexes must leave both markers alone.
        write_reg(REG_SPARE_LO, 8'h33);
        write_reg(REG_SPARE_HI, 8'h44);
      end
      write_reg(trfp_pkg::REG_START_MARKER, phase_start[p]);
      write_reg(trfp_pkg::REG_END_MARKER, phase_end[p]);
      cfg_valid <= 1'b0;
      no_gaps = (p == 2);
      frame_bytes = 0;
      while (frame_bytes < PHASE_BYTES) random_frame();
    end
    no_gaps = 1'b0;

    settle();
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: sim.f
rtl/trfp_pkg.sv
rtl/trfp_front.sv
rtl/trfp_queue.sv
rtl/trfp_back.sv
rtl/target_report_frame_parser.sv
tb/sv/tb.sv
